@@ rtl/core/websocket_frame_header_parser_assert.svh @@
// Assertion macros used by the frame header parser RTL.
`ifndef WEBSOCKET_FRAME_HEADER_PARSER_ASSERT_SVH
`define WEBSOCKET_FRAME_HEADER_PARSER_ASSERT_SVH

`ifndef SYNTH
// Clocked check, disabled while reset is asserted.
`define WSFHP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("wsfhp assertion failed");
// Clocked check that also holds during reset.
`define WSFHP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("wsfhp assertion failed");
`else
`define WSFHP_ASSERT(lbl, clk, rst_n, prop)
`define WSFHP_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ rtl/core/wsfhp_pkg.sv @@
// Types, codes and helper functions for the frame header parser.
`timescale 1ns / 1ps
`default_nettype none

package wsfhp_pkg;

    // Parse phase of the frame currently on the stream
    typedef enum logic [2:0] {
        PH_BYTE0   = 3'd0,
        PH_BYTE1   = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_KEY     = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    // Length encoding forms
    localparam logic [1:0] LF_7  = 2'd0;
    localparam logic [1:0] LF_16 = 2'd1;
    localparam logic [1:0] LF_64 = 2'd2;

    // Status codes
    localparam logic [1:0] ST_PROGRESS = 2'd0;
    localparam logic [1:0] ST_DONE     = 2'd1;
    localparam logic [1:0] ST_EOB      = 2'd2;

    // Seven-bit length codes that select an extended length
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    // Header byte counts
    localparam logic [3:0] BASE_HDR_BYTES = 4'd2;
    localparam logic [3:0] KEY_BYTES      = 4'd4;
    localparam logic [3:0] MAX_HDR_BYTES  = 4'd14;

    // One result transaction
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        is_payload;
        logic        header_valid;
        logic        fin_flag;
        logic [3:0]  frame_opcode;
        logic        mask_flag;
        logic [31:0] mask_key;
        logic [63:0] payload_length;
        logic [1:0]  length_form;
        logic [3:0]  header_bytes;
        logic [1:0]  status;
    } result_t;

    // Number of extended length bytes for a length form
    function automatic logic [3:0] ext_bytes(input logic [1:0] lf);
        logic [3:0] n;
        n = 4'd0;
        if (lf == LF_16) n = 4'd2;
        else if (lf == LF_64) n = 4'd8;
        return n;
    endfunction

    // Full header size in bytes
    function automatic logic [3:0] hdr_size(input logic [1:0] lf, input logic mask);
        return BASE_HDR_BYTES + ext_bytes(lf) + (mask ? KEY_BYTES : 4'd0);
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/websocket_frame_header_parser.sv @@
// Path: an accepted byte is held in the input register, decoded by the parse logic,
// and captured in the result register. Throughput: one byte per cycle; the parse state
// update is combinational between the two registers. A held result stalls input.
// Reset: rst_n clears both stage valid flags and returns the parser to the
// first header byte with all frame fields zero.
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_header_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        end_of_buffer,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       data_byte,
    output logic             is_payload,
    output logic             header_valid,
    output logic             fin_flag,
    output logic [3:0]       frame_opcode,
    output logic             mask_flag,
    output logic [31:0]      mask_key,
    output logic [63:0]      payload_length,
    output logic [1:0]       length_form,
    output logic [3:0]       header_bytes,
    output logic [1:0]       status
);
    import wsfhp_pkg::*;

    logic       advance;
    logic       stage_valid;
    logic [7:0] stage_byte;
    logic       stage_eob;
    result_t    parse_result;
    result_t    out_result;

    wsfhp_in_stage u_in (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .end_of_buffer (end_of_buffer),
        .advance       (advance),
        .stage_valid   (stage_valid),
        .stage_byte    (stage_byte),
        .stage_eob     (stage_eob)
    );

    wsfhp_parse u_parse (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .rx_byte       (stage_byte),
        .end_of_buffer (stage_eob),
        .result        (parse_result)
    );

    wsfhp_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (stage_valid),
        .up_result  (parse_result),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_result (out_result)
    );

    // Break the result out onto ports
    assign data_byte      = out_result.data_byte;
    assign is_payload     = out_result.is_payload;
    assign header_valid   = out_result.header_valid;
    assign fin_flag       = out_result.fin_flag;
    assign frame_opcode   = out_result.frame_opcode;
    assign mask_flag      = out_result.mask_flag;
    assign mask_key       = out_result.mask_key;
    assign payload_length = out_result.payload_length;
    assign length_form    = out_result.length_form;
    assign header_bytes   = out_result.header_bytes;
    assign status         = out_result.status;

endmodule

`default_nettype wire

@@ rtl/core/wsfhp_in_stage.sv @@
// Input register stage: captures one byte transaction from the stream.
`timescale 1ns / 1ps
`default_nettype none

module wsfhp_in_stage (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    input  wire logic       end_of_buffer,
    input  wire logic       advance,
    output logic            stage_valid,
    output logic [7:0]      stage_byte,
    output logic            stage_eob
);
    import wsfhp_pkg::*;

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       eob_reg;

    // Accept when empty or when the held byte moves on this cycle
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load payload on acceptance
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
            eob_reg  <= end_of_buffer;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_byte  = byte_reg;
    assign stage_eob   = eob_reg;

endmodule

`default_nettype wire

@@ rtl/core/wsfhp_parse.sv @@
// Frame parse state and the per-byte decode that forms each result.
`timescale 1ns / 1ps
`default_nettype none
`include "websocket_frame_header_parser_assert.svh"

module wsfhp_parse (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       advance,
    input  wire logic [7:0] rx_byte,
    input  wire logic       end_of_buffer,
    output wsfhp_pkg::result_t result
);
    import wsfhp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  idx_reg, idx_next;
    logic        fin_reg, fin_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        mask_reg, mask_next;
    logic [1:0]  lf_reg, lf_next;
    logic [63:0] len_reg, len_next;
    logic [31:0] key_reg, key_next;
    logic [63:0] rem_reg, rem_next;

    logic        payload;
    logic        hvalid;
    logic        done;
    logic [1:0]  key_slot;
    logic [3:0]  key_off;

    assign key_off  = idx_reg - BASE_HDR_BYTES - ext_bytes(lf_reg);
    assign key_slot = key_off[1:0];

    // Decode one byte against the current parse phase
    always_comb
    begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        fin_next    = fin_reg;
        opcode_next = opcode_reg;
        mask_next   = mask_reg;
        lf_next     = lf_reg;
        len_next    = len_reg;
        key_next    = key_reg;
        rem_next    = rem_reg;
        payload     = 1'b0;
        hvalid      = 1'b0;
        done        = 1'b0;

        unique case (phase_reg)
            PH_BYTE1:
            begin
                mask_next = rx_byte[7];
                idx_next  = BASE_HDR_BYTES;
                if (rx_byte[6:0] == LEN_CODE_16)
                begin
                    lf_next    = LF_16;
                    len_next   = '0;
                    phase_next = PH_EXTLEN;
                end
                else if (rx_byte[6:0] == LEN_CODE_64)
                begin
                    lf_next    = LF_64;
                    len_next   = '0;
                    phase_next = PH_EXTLEN;
                end
                else
                begin
                    lf_next  = LF_7;
                    len_next = {57'd0, rx_byte[6:0]};
                    if (rx_byte[7])
                    begin
                        phase_next = PH_KEY;
                    end
                    else
                    begin
                        hvalid = 1'b1;
                    end
                end
            end
            PH_EXTLEN:
            begin
                // Shift in big-endian length bytes
                len_next = {len_reg[55:0], rx_byte};
                idx_next = idx_reg + 4'd1;
                if (idx_next >= BASE_HDR_BYTES + ext_bytes(lf_reg))
                begin
                    if (mask_reg)
                    begin
                        phase_next = PH_KEY;
                    end
                    else
                    begin
                        hvalid = 1'b1;
                    end
                end
            end
            PH_KEY:
            begin
                // First key byte lands in the low bits
                key_next = key_reg | ({24'd0, rx_byte} << {key_slot, 3'b000});
                idx_next = idx_reg + 4'd1;
                if (idx_next >= hdr_size(lf_reg, mask_reg))
                begin
                    hvalid = 1'b1;
                end
            end
            PH_PAYLOAD:
            begin
                payload  = 1'b1;
                rem_next = rem_reg - 64'd1;
                if (rem_next == 64'd0)
                begin
                    phase_next = PH_BYTE0;
                    done       = 1'b1;
                end
            end
            default:
            begin
                // First header byte: start a new frame
                fin_next    = rx_byte[7];
                opcode_next = rx_byte[3:0];
                mask_next   = 1'b0;
                lf_next     = LF_7;
                len_next    = '0;
                key_next    = '0;
                rem_next    = '0;
                idx_next    = 4'd1;
                phase_next  = PH_BYTE1;
            end
        endcase

        // Header complete: zero length ends the frame here
        if (hvalid)
        begin
            if (len_next == 64'd0)
            begin
                phase_next = PH_BYTE0;
                done       = 1'b1;
            end
            else
            begin
                rem_next   = len_next;
                phase_next = PH_PAYLOAD;
            end
        end
    end

    // Form the result transaction
    always_comb
    begin
        result.data_byte      = rx_byte;
        result.is_payload     = payload;
        result.header_valid   = hvalid;
        result.fin_flag       = fin_next;
        result.frame_opcode   = opcode_next;
        result.mask_flag      = mask_next;
        result.mask_key       = key_next;
        result.payload_length = len_next;
        result.length_form    = lf_next;
        result.header_bytes   = hdr_size(lf_next, mask_next);
        priority if (done)
        begin
            result.status = ST_DONE;
        end
        else if (end_of_buffer)
        begin
            result.status = ST_EOB;
        end
        else
        begin
            result.status = ST_PROGRESS;
        end
    end

    // Advance parse state once per byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_BYTE0;
            idx_reg    <= '0;
            fin_reg    <= 1'b0;
            opcode_reg <= '0;
            mask_reg   <= 1'b0;
            lf_reg     <= LF_7;
            len_reg    <= '0;
            key_reg    <= '0;
            rem_reg    <= '0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            fin_reg    <= fin_next;
            opcode_reg <= opcode_next;
            mask_reg   <= mask_next;
            lf_reg     <= lf_next;
            len_reg    <= len_next;
            key_reg    <= key_next;
            rem_reg    <= rem_next;
        end
    end

    `WSFHP_ASSERT(a_payload_rem_nonzero, clk, rst_n, (phase_reg == PH_PAYLOAD) |-> (rem_reg != 64'd0))
    `WSFHP_ASSERT(a_byte0_rem_zero, clk, rst_n, (phase_reg == PH_BYTE0) |-> (rem_reg == 64'd0))
    `WSFHP_ASSERT(a_hdr_not_payload, clk, rst_n, result.header_valid |-> !result.is_payload)
    `WSFHP_ASSERT(a_payload_step, clk, rst_n, (advance && phase_reg == PH_PAYLOAD) |=> ($past(rem_reg) == rem_reg + 64'd1))
    `WSFHP_ASSERT(a_idx_bound, clk, rst_n, idx_reg <= MAX_HDR_BYTES)

endmodule

`default_nettype wire

@@ rtl/core/wsfhp_out_stage.sv @@
// Result register stage: holds one result transaction until taken.
`timescale 1ns / 1ps
`default_nettype none

module wsfhp_out_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          up_valid,
    input  wire wsfhp_pkg::result_t up_result,
    output logic               advance,
    output logic               out_valid,
    input  wire logic          out_ready,
    output wsfhp_pkg::result_t out_result
);
    import wsfhp_pkg::*;

    logic    valid_reg, valid_next;
    result_t result_reg;

    // Load when empty or when the held result is taken this cycle
    assign advance = up_valid && (!valid_reg || out_ready);

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the result
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= up_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire

@@ bench/frame_field_checker.sv @@
// Result checker for the frame header parser: predicts every result and compares it.
`timescale 1ns / 1ps

module frame_field_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        end_of_buffer,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  data_byte,
    input  logic        is_payload,
    input  logic        header_valid,
    input  logic        fin_flag,
    input  logic [3:0]  frame_opcode,
    input  logic        mask_flag,
    input  logic [31:0] mask_key,
    input  logic [63:0] payload_length,
    input  logic [1:0]  length_form,
    input  logic [3:0]  header_bytes,
    input  logic [1:0]  status,
    output int          errors,
    output int          pending
);
    import wsfhp_pkg::*;

    // Parser state as the predictor tracks it
    phase_t      phase;
    logic [3:0]  hdr_idx;
    logic        fin_q;
    logic [3:0]  opcode_q;
    logic        mask_q;
    logic [1:0]  form_q;
    logic [63:0] len_q;
    logic [31:0] key_q;
    logic [63:0] left_q;

    result_t predicted_fields[$];
    result_t seen;
    result_t want;

    initial errors = 0;

    // Extended length bytes carried by a length form
    function automatic logic [3:0] ext_count(input logic [1:0] form);
        case (form)
            LF_16:   return 4'd2;
            LF_64:   return 4'd8;
            default: return 4'd0;
        endcase
    endfunction

    // Print one mismatch line (capped) and count it
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        errors++;
        if (errors <= 100)
            $display("%0t checker: %s got %0h expected %0h", $time, what, got, exp_val);
    endtask

    task automatic compare_field(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
        if (got !== exp_val)
            report_mismatch(what, got, exp_val);
    endtask

    // Advance the parser state by one byte and form the result it produces
    task automatic decode_byte(input logic [7:0] b, input logic eob, output result_t r);
        logic       hvalid;
        logic       done;
        logic       payload;
        logic [3:0] off;
        hvalid  = 1'b0;
        done    = 1'b0;
        payload = 1'b0;
        case (phase)
            PH_BYTE1:
            begin
                mask_q  = b[7];
                hdr_idx = BASE_HDR_BYTES;
                if (b[6:0] == LEN_CODE_16 || b[6:0] == LEN_CODE_64)
                begin
                    form_q = (b[6:0] == LEN_CODE_16) ? LF_16 : LF_64;
                    len_q  = '0;
                    phase  = PH_EXTLEN;
                end
                else
                begin
                    form_q = LF_7;
                    len_q  = {57'd0, b[6:0]};
                    if (mask_q)
                        phase = PH_KEY;
                    else
                        hvalid = 1'b1;
                end
            end
            PH_EXTLEN:
            begin
                len_q   = {len_q[55:0], b};
                hdr_idx = hdr_idx + 4'd1;
                if (hdr_idx >= BASE_HDR_BYTES + ext_count(form_q))
                begin
                    if (mask_q)
                        phase = PH_KEY;
                    else
                        hvalid = 1'b1;
                end
            end
            PH_KEY:
            begin
                off     = hdr_idx - BASE_HDR_BYTES - ext_count(form_q);
                key_q   = key_q | ({24'd0, b} << {off[1:0], 3'b000});
                hdr_idx = hdr_idx + 4'd1;
                if (hdr_idx >= BASE_HDR_BYTES + ext_count(form_q) + KEY_BYTES)
                    hvalid = 1'b1;
            end
            PH_PAYLOAD:
            begin
                payload = 1'b1;
                left_q  = left_q - 64'd1;
                if (left_q == 64'd0)
                begin
                    phase = PH_BYTE0;
                    done  = 1'b1;
                end
            end
            default:
            begin
                fin_q    = b[7];
                opcode_q = b[3:0];
                mask_q   = 1'b0;
                form_q   = LF_7;
                len_q    = '0;
                key_q    = '0;
                left_q   = '0;
                hdr_idx  = 4'd1;
                phase    = PH_BYTE1;
            end
        endcase

        // Close the header: a zero-length frame ends here, else count the payload
        if (hvalid)
        begin
            if (len_q == 64'd0)
            begin
                phase = PH_BYTE0;
                done  = 1'b1;
            end
            else
            begin
                left_q = len_q;
                phase  = PH_PAYLOAD;
            end
        end

        r.data_byte      = b;
        r.is_payload     = payload;
        r.header_valid   = hvalid;
        r.fin_flag       = fin_q;
        r.frame_opcode   = opcode_q;
        r.mask_flag      = mask_q;
        r.mask_key       = key_q;
        r.payload_length = len_q;
        r.length_form    = form_q;
        r.header_bytes   = BASE_HDR_BYTES + ext_count(form_q) + (mask_q ? KEY_BYTES : 4'd0);
        r.status         = done ? ST_DONE : (eob ? ST_EOB : ST_PROGRESS);
    endtask

    // Compare each result transaction, then predict each byte transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase    = PH_BYTE0;
            hdr_idx  = '0;
            fin_q    = 1'b0;
            opcode_q = '0;
            mask_q   = 1'b0;
            form_q   = LF_7;
            len_q    = '0;
            key_q    = '0;
            left_q   = '0;
            predicted_fields.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (predicted_fields.size() == 0)
                    report_mismatch("result with nothing expected", data_byte, '0);
                else
                begin
                    want = predicted_fields.pop_front();
                    compare_field("data_byte", data_byte, want.data_byte);
                    compare_field("is_payload", is_payload, want.is_payload);
                    compare_field("header_valid", header_valid, want.header_valid);
                    compare_field("fin_flag", fin_flag, want.fin_flag);
                    compare_field("frame_opcode", frame_opcode, want.frame_opcode);
                    compare_field("mask_flag", mask_flag, want.mask_flag);
                    compare_field("mask_key", mask_key, want.mask_key);
                    compare_field("payload_length", payload_length, want.payload_length);
                    compare_field("length_form", length_form, want.length_form);
                    compare_field("header_bytes", header_bytes, want.header_bytes);
                    compare_field("status", status, want.status);
                end
            end
            if (in_valid && in_ready)
            begin
                decode_byte(rx_byte, end_of_buffer, seen);
                predicted_fields.push_back(seen);
            end
            pending <= predicted_fields.size();
        end
    end

endmodule

@@ bench/tb.sv @@
// Testbench top for the frame header parser: clock, reset, frame stimulus and verdict.
`timescale 1ns / 1ps

module tb;
    import wsfhp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int BYTE_TARGET = 1050;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic [7:0] rx_byte = '0;
    logic end_of_buffer = 1'b0;
    logic out_ready = 1'b0;
    logic steady = 1'b0;

    logic        in_ready;
    logic        out_valid;
    logic [7:0]  data_byte;
    logic        is_payload;
    logic        header_valid;
    logic        fin_flag;
    logic [3:0]  frame_opcode;
    logic        mask_flag;
    logic [31:0] mask_key;
    logic [63:0] payload_length;
    logic [1:0]  length_form;
    logic [3:0]  header_bytes;
    logic [1:0]  status;

    int mismatches;
    int pending;
    int cycles = 0;
    int bytes_sent = 0;
    logic drained_once = 1'b0;

    always #5 clk = ~clk;

    always @(posedge clk)
        cycles <= cycles + 1;

    websocket_frame_header_parser uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .end_of_buffer  (end_of_buffer),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .data_byte      (data_byte),
        .is_payload     (is_payload),
        .header_valid   (header_valid),
        .fin_flag       (fin_flag),
        .frame_opcode   (frame_opcode),
        .mask_flag      (mask_flag),
        .mask_key       (mask_key),
        .payload_length (payload_length),
        .length_form    (length_form),
        .header_bytes   (header_bytes),
        .status         (status)
    );

    frame_field_checker field_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .end_of_buffer  (end_of_buffer),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .data_byte      (data_byte),
        .is_payload     (is_payload),
        .header_valid   (header_valid),
        .fin_flag       (fin_flag),
        .frame_opcode   (frame_opcode),
        .mask_flag      (mask_flag),
        .mask_key       (mask_key),
        .payload_length (payload_length),
        .length_form    (length_form),
        .header_bytes   (header_bytes),
        .status         (status),
        .errors         (mismatches),
        .pending        (pending)
    );

    // Stall the result side at random, except in the steady stretch
    always @(posedge clk)
        out_ready <= steady || ($urandom_range(99) >= 17);

    // Mark a byte as the last one in the buffer now and then
    function automatic logic rand_eob();
        return $urandom_range(9) == 0;
    endfunction

    // Offer one byte transaction, with random gaps ahead of it, and hold until taken
    task automatic send_byte(input logic [7:0] b, input logic eob);
        while (!steady && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        rx_byte       <= b;
        end_of_buffer <= eob;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Send a frame header and a given number of payload bytes
    task automatic send_frame(input logic [7:0] head, input logic [1:0] form,
                              input logic masked, input logic [63:0] len,
                              input logic [31:0] key, input int body);
        logic [6:0] code;
        int         n;
        code = (form == LF_16) ? LEN_CODE_16 : (form == LF_64) ? LEN_CODE_64 : len[6:0];
        n = (form == LF_16) ? 2 : (form == LF_64) ? 8 : 0;
        send_byte(head, rand_eob());
        send_byte({masked, code}, rand_eob());
        for (int i = n - 1; i >= 0; i--)
            send_byte(len[8*i +: 8], rand_eob());
        if (masked)
            for (int i = 0; i < 4; i++)
                send_byte(key[8*i +: 8], rand_eob());
        for (int i = 0; i < body; i++)
            send_byte(8'($urandom_range(255)), rand_eob());
    endtask

    // Pick a random well-formed frame, mostly short
    task automatic random_frame();
        int         pick;
        logic [1:0] form;
        logic [63:0] len;
        pick = $urandom_range(99);
        if (pick < 60)
        begin
            form = LF_7;
            len  = ($urandom_range(19) == 0) ? 64'($urandom_range(125, 13))
                                             : 64'($urandom_range(12));
        end
        else if (pick < 80)
        begin
            form = LF_16;
            len  = ($urandom_range(19) == 0) ? 64'($urandom_range(300, 256))
                                             : 64'($urandom_range(20));
        end
        else
        begin
            form = LF_64;
            len  = 64'($urandom_range(20));
        end
        send_frame(8'($urandom_range(255)), form, 1'($urandom_range(1)), len,
                   $urandom, int'(len));
    endtask

    // Hold the sender until every predicted result has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed frames: zero-length unmasked, masked short, 16-bit, zero-length masked 64-bit
        send_frame(8'h81, LF_7, 1'b0, 64'd0, 32'h0, 0);
        send_frame(8'hF0, LF_7, 1'b1, 64'd1, 32'h5AA5FF00, 1);
        send_frame(8'h02, LF_16, 1'b0, 64'd1, 32'h0, 1);
        send_frame(8'h7F, LF_64, 1'b1, 64'd0, 32'hFFFFFFFF, 0);
        drain();

        // Random frames, with one steady stretch and one full drain midway
        while (bytes_sent < BYTE_TARGET)
        begin
            steady <= (bytes_sent >= 300 && bytes_sent < 450);
            if (!drained_once && bytes_sent >= 600)
            begin
                drain();
                drained_once = 1'b1;
            end
            random_frame();
        end
        steady <= 1'b0;

        // Close with a 64-bit length that has its top bit set; leave the frame open
        send_frame(8'h89, LF_64, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, $urandom, 3);
        drain();
        repeat (10) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // End a hung run
    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("tb: done, errors");
        $finish;
    end

endmodule
